// ===== rtl/first_seen_value_labeler_core_assert.svh =====
// ----------------------------------------------------------------------------
// first_seen_value_labeler_core_assert.svh
// assertion macros used by the checker file of the labeler core
// ----------------------------------------------------------------------------
`ifndef FIRST_SEEN_VALUE_LABELER_CORE_ASSERT_SVH
`define FIRST_SEEN_VALUE_LABELER_CORE_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define FSLV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is high
`define FSLV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fslv_pkg.sv =====
// ----------------------------------------------------------------------------
// fslv_pkg
// types and constants shared by the first-seen value labeler
// ----------------------------------------------------------------------------
package fslv_pkg;

  localparam int KEY_W = 32;
  localparam int LBL_W = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic tbl_empty;
    logic match;
    logic at_end;
    logic slot_free;
  } stat_t;

  // controls from the sequencer to the datapath
  typedef struct packed {
    logic in_ready;
    logic searching;
    logic commit;
  } ctrl_t;

endpackage

// ===== rtl/fslv_mem.sv =====
// ----------------------------------------------------------------------------
// fslv_mem
// table of distinct keys: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module fslv_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [fslv_pkg::KEY_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [fslv_pkg::KEY_W-1:0] rdata
);
  import fslv_pkg::*;

  logic [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fslv_ctrl.sv =====
// ----------------------------------------------------------------------------
// fslv_ctrl
// sequencer: take an item, step through the table, hand the result over
// ----------------------------------------------------------------------------
module fslv_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  fslv_pkg::stat_t stat,
  output fslv_pkg::ctrl_t ctrl
);
  import fslv_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (stat.in_valid) begin
          state_next = stat.tbl_empty ? ST_DONE : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (stat.match || stat.at_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state)
      ST_IDLE:   ctrl.in_ready  = 1'b1;
      ST_SEARCH: ctrl.searching = 1'b1;
      ST_DONE:   ctrl.commit    = stat.slot_free;
      default:   ctrl = '0;
    endcase
  end

endmodule

// ===== rtl/first_seen_value_labeler_core.sv =====
// ----------------------------------------------------------------------------
// first_seen_value_labeler_core
// labels each value by its position in the table of distinct values of a field
// ----------------------------------------------------------------------------
// One item is taken at a time. Its search compares n entries, where n is the
// number of stored entries compared before a match is found or the table runs
// out (0 for an empty table, at most CAPACITY). The table sits in one
// memory with a single read port and one entry is compared per cycle. A
// finished result waits in the output register and the next item is taken
// while it does. The table is cleared after an item with last_of_field set;
// no clearing pass is needed, the fill count marks which entries are live.
// ----------------------------------------------------------------------------
module first_seen_value_labeler_core #(
  parameter int CAPACITY = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [fslv_pkg::KEY_W-1:0] value,
  input  logic                       last_of_field,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [fslv_pkg::LBL_W-1:0] label,
  output logic                       is_new,
  output logic                       overflow,
  output logic [fslv_pkg::LBL_W-1:0] distinct_count
);
  import fslv_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  stat_t stat;
  ctrl_t ctrl;

  logic [KEY_W-1:0] key;
  logic             last;
  logic [IW-1:0]    cmp_idx;
  logic             found;
  logic [CW-1:0]    count;

  logic [IW-1:0]    rd_addr;
  logic [KEY_W-1:0] rd_data;
  logic             accept;
  logic             full;
  logic             append;
  logic [CW-1:0]    res_lbl;
  logic [CW-1:0]    count_after;

  // no item is taken while reset is high
  assign in_ready = ctrl.in_ready && !rst;
  assign accept   = in_valid && in_ready;

  // the entry compared next cycle is fetched now, as the read data is registered
  assign rd_addr = ctrl.searching ? cmp_idx + IW'(1) : '0;

  assign full        = (count == CW'(CAPACITY));
  assign append      = !found && !full;
  assign res_lbl     = found ? CW'(cmp_idx) : (full ? CW'(CAPACITY) : count);
  assign count_after = append ? count + CW'(1) : count;

  assign stat.in_valid  = in_valid;
  assign stat.tbl_empty = (count == '0);
  assign stat.match     = ctrl.searching && (rd_data == key);
  assign stat.at_end    = (CW'(cmp_idx) + CW'(1) == count);
  assign stat.slot_free = !out_valid || out_ready;

  fslv_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  fslv_mem #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (ctrl.commit && append),
    .waddr (count[IW-1:0]),
    .wdata (key),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      key     <= value;
      last    <= last_of_field;
      cmp_idx <= '0;
      found   <= 1'b0;
    end else if (ctrl.searching) begin
      if (stat.match) begin
        found <= 1'b1;
      end else if (!stat.at_end) begin
        cmp_idx <= cmp_idx + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.commit) begin
      count <= last ? '0 : count_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // labels and counts are reported modulo the 7-bit field width
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      label          <= LBL_W'(res_lbl);
      distinct_count <= LBL_W'(count_after);
      is_new         <= append;
      overflow       <= !found && full;
    end
  end

endmodule

// ===== rtl/fslv_checker.sv =====
// ----------------------------------------------------------------------------
// fslv_checker
// port-level checks on the labeler core, bound to the top level
// ----------------------------------------------------------------------------
`include "first_seen_value_labeler_core_assert.svh"

module fslv_checker #(
  parameter int CAPACITY = 64
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [fslv_pkg::LBL_W-1:0] label,
  input logic                       is_new,
  input logic                       overflow,
  input logic [fslv_pkg::LBL_W-1:0] distinct_count
);
  import fslv_pkg::*;

  `FSLV_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(label) && $stable(distinct_count), "stalled result changed")
  `FSLV_ASSERT_NOW(a_new_xor_ovf, clk, rst, out_valid,
    !(is_new && overflow), "item both new and overflowed")
  `FSLV_ASSERT_NOW(a_ovf_full, clk, rst, out_valid && overflow,
    (label == LBL_W'(CAPACITY)) && (distinct_count == LBL_W'(CAPACITY)),
    "overflow without full table")
  `FSLV_ASSERT_NOW(a_new_last, clk, rst, out_valid && is_new,
    LBL_W'(label + LBL_W'(1)) == distinct_count, "new label is not the last entry")
  `FSLV_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready,
    !in_ready, "second item taken during a search")

endmodule

bind first_seen_value_labeler_core fslv_checker #(.CAPACITY(CAPACITY)) u_fslv_checker (.*);
